>>> rtl/tpsg_pkg.sv
// Shared types, codes and constants of the three-phase sine gate sequencer.
`timescale 1ns / 1ps

package tpsg_pkg;

  localparam int TABLE_DEPTH_DEFAULT = 720;

  localparam int SAMPLE_W    = 8;
  localparam int GATE_W      = 6;
  localparam int INDEX_W     = 10;
  localparam int OP_W        = 2;
  localparam int S_TDATA_W   = 24;
  localparam int M_TDATA_W   = 8;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int OUT_DEPTH   = 8;
  localparam int OUT_PTR_W   = 3;
  localparam int OUT_CNT_W   = 4;

  typedef logic [OP_W-1:0] op_t;
  localparam op_t OP_SAMPLE      = 2'd0;
  localparam op_t OP_PROFILE     = 2'd1;
  localparam op_t OP_TABLE_WRITE = 2'd2;

  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
  localparam cfg_index_t CFG_PHASE_GAIN      = 3'd0;
  localparam cfg_index_t CFG_UPPER_THRESHOLD = 3'd1;
  localparam cfg_index_t CFG_LOWER_THRESHOLD = 3'd2;
  localparam cfg_index_t CFG_STEP_TICKS      = 3'd3;
  localparam cfg_index_t CFG_PAUSE_TICKS     = 3'd4;
  localparam cfg_index_t CFG_FREQ_LOW        = 3'd5;
  localparam cfg_index_t CFG_FREQ_MID        = 3'd6;
  localparam cfg_index_t CFG_FREQ_HIGH       = 3'd7;

  localparam logic [15:0] PHASE_GAIN_RESET      = 16'd17572;
  localparam logic [7:0]  UPPER_THRESHOLD_RESET = 8'd129;
  localparam logic [7:0]  LOWER_THRESHOLD_RESET = 8'd125;
  localparam logic [9:0]  STEP_TICKS_RESET      = 10'd10;
  localparam logic [9:0]  PAUSE_TICKS_RESET     = 10'd50;
  localparam logic [7:0]  FREQ_LOW_RESET        = 8'd40;
  localparam logic [7:0]  FREQ_MID_RESET        = 8'd80;
  localparam logic [7:0]  FREQ_HIGH_RESET       = 8'd120;
  localparam logic [7:0]  FREQUENCY_RESET       = 8'd60;

  localparam logic [GATE_W-1:0] GATE_ALL_OFF = 6'h3F;

  typedef enum logic [3:0] {
    PS_START,
    PS_LOW,
    PS_MID,
    PS_HIGH,
    PS_PAUSE,
    PS_REV_LOW,
    PS_REV_MID,
    PS_REV_HIGH,
    PS_REV_PAUSE
  } profile_state_t;

  typedef enum logic [1:0] {
    CL_OFF,
    CL_HIGH,
    CL_LOW
  } sample_class_t;

  typedef struct packed {
    logic              last;
    logic [GATE_W-1:0] gate;
  } out_beat_t;

  function automatic sample_class_t classify(logic [SAMPLE_W-1:0] s,
                                             logic [SAMPLE_W-1:0] upper,
                                             logic [SAMPLE_W-1:0] lower);
    sample_class_t c;
    if (s > upper) begin
      c = CL_HIGH;
    end else if (s < lower) begin
      c = CL_LOW;
    end else begin
      c = CL_OFF;
    end
    return c;
  endfunction

  // reduce an 8-bit count of table steps below depth, one restoring step per bit
  function automatic logic [7:0] reduce_steps(logic [7:0] v, int unsigned depth);
    int unsigned rv;
    rv = 32'(v);
    for (int k = 7; k >= 0; k--) begin
      if (rv >= (depth << k)) begin
        rv = rv - (depth << k);
      end
    end
    return 8'(rv);
  endfunction

endpackage

>>> rtl/three_phase_sine_gate_sequencer.sv
// Top level of the three-phase sine gate sequencer.
`timescale 1ns / 1ps
// The break beat of a sample tick with drive enabled is queued once its three table reads are
//   classified, the final beat after it; profile ticks and table writes give no beat.
// The three sine-table reads of a sample tick share the table RAM's single read port, so a new
//   sample tick is taken only once the last read of the previous one is being issued.
// A sample tick is held off after a profile tick or a register write while the increment
//   multiplier settles; a table write waits for pending table reads.
// Reset (rst, synchronous): registers, accumulator, profile and gates return to defaults.

module three_phase_sine_gate_sequencer #(
  parameter int TABLE_DEPTH = tpsg_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [9:0] table_index, [17:10] table_value, [23:18] zero
  input  logic [tpsg_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  // [1:0] op
  input  logic [tpsg_pkg::OP_W-1:0]          s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [5:0] gate_pattern, [7:6] zero
  output logic [tpsg_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  output logic                               m_axis_tlast,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tpsg_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [tpsg_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam longint unsigned PERIOD = 64'(TABLE_DEPTH) * 64'd65536;
  localparam longint unsigned OFF1   = PERIOD / 3;
  localparam longint unsigned OFF2   = (2 * PERIOD) / 3;
  localparam logic [AW-1:0] OFF1_IDX  = AW'(OFF1 >> 16);
  localparam logic [15:0]   OFF1_FRAC = 16'(OFF1 & 64'hFFFF);
  localparam logic [AW-1:0] OFF2_IDX  = AW'(OFF2 >> 16);
  localparam logic [15:0]   OFF2_FRAC = 16'(OFF2 & 64'hFFFF);
  localparam logic [AW:0]   IDX_LIM   = (AW + 1)'(TABLE_DEPTH);
  localparam int GW = tpsg_pkg::GATE_W;
  localparam int CW = tpsg_pkg::OUT_CNT_W;

  function automatic logic [AW+15:0] add_wrap(logic [AW-1:0] a_idx, logic [15:0] a_frac,
                                              logic [AW-1:0] b_idx, logic [15:0] b_frac);
    logic [16:0] fs;
    logic [AW:0] is;
    fs = {1'b0, a_frac} + {1'b0, b_frac};
    is = {1'b0, a_idx} + {1'b0, b_idx} + {{AW{1'b0}}, fs[16]};
    if (is >= IDX_LIM) begin
      is = is - IDX_LIM;
    end
    return {is[AW-1:0], fs[15:0]};
  endfunction

  logic [15:0] phase_gain;
  logic [7:0]  upper_threshold;
  logic [7:0]  lower_threshold;
  logic [9:0]  step_ticks;
  logic [9:0]  pause_ticks;
  logic [7:0]  freq_low;
  logic [7:0]  freq_mid;
  logic [7:0]  freq_high;

  tpsg_pkg::op_t s_op;
  logic [tpsg_pkg::INDEX_W-1:0]  s_idx;
  logic [tpsg_pkg::SAMPLE_W-1:0] s_val;
  logic s_acc, smp_acc, prf_acc, tw_acc, idx_ok;

  tpsg_pkg::profile_state_t prof, prof_next;
  logic [9:0] tick_count, tick_next, cnt_inc, limit;
  logic       adv;
  logic [7:0] frequency, freq_next;
  logic       drive_enable, en_next;
  logic       normal_order, ord_next;

  logic [1:0]    settle;
  logic [23:0]   prod;
  logic [15:0]   inc_frac;
  logic [AW-1:0] inc_idx;

  logic [AW-1:0]  acc_idx;
  logic [15:0]    acc_frac;
  logic [AW+15:0] acc_sum, ph1_sum, ph2_sum;
  logic [AW-1:0]  ph1, ph2;

  logic [1:0] rd_cnt, rv_cnt;
  logic       rd_free;
  logic       j_en, j_ord, f_en, f_ord;

  logic                          re;
  logic [AW-1:0]                 raddr;
  logic [tpsg_pkg::SAMPLE_W-1:0] rdata;

  tpsg_pkg::sample_class_t cls_a, cls_b;
  tpsg_pkg::sample_class_t cls_ph [3];
  logic [GW-1:0] on_mask, off_mask, brk, fin, gate_reg;
  logic          fin_en;

  tpsg_pkg::out_beat_t ent [tpsg_pkg::OUT_DEPTH];
  tpsg_pkg::out_beat_t head;
  logic [tpsg_pkg::OUT_PTR_W-1:0] wptr, rptr;
  logic [CW-1:0] cnt, used, push_n;
  logic          pop;

  assign s_op  = s_axis_tuser;
  assign s_idx = s_axis_tdata[9:0];
  assign s_val = s_axis_tdata[17:10];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_gain      <= tpsg_pkg::PHASE_GAIN_RESET;
      upper_threshold <= tpsg_pkg::UPPER_THRESHOLD_RESET;
      lower_threshold <= tpsg_pkg::LOWER_THRESHOLD_RESET;
      step_ticks      <= tpsg_pkg::STEP_TICKS_RESET;
      pause_ticks     <= tpsg_pkg::PAUSE_TICKS_RESET;
      freq_low        <= tpsg_pkg::FREQ_LOW_RESET;
      freq_mid        <= tpsg_pkg::FREQ_MID_RESET;
      freq_high       <= tpsg_pkg::FREQ_HIGH_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        tpsg_pkg::CFG_PHASE_GAIN:      phase_gain      <= cfg_data;
        tpsg_pkg::CFG_UPPER_THRESHOLD: upper_threshold <= cfg_data[7:0];
        tpsg_pkg::CFG_LOWER_THRESHOLD: lower_threshold <= cfg_data[7:0];
        tpsg_pkg::CFG_STEP_TICKS:      step_ticks      <= cfg_data[9:0];
        tpsg_pkg::CFG_PAUSE_TICKS:     pause_ticks     <= cfg_data[9:0];
        tpsg_pkg::CFG_FREQ_LOW:        freq_low        <= cfg_data[7:0];
        tpsg_pkg::CFG_FREQ_MID:        freq_mid        <= cfg_data[7:0];
        tpsg_pkg::CFG_FREQ_HIGH:       freq_high       <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign rd_free = (rd_cnt == 2'd0) || (rd_cnt == 2'd3);

  always_comb begin
    case (s_op)
      tpsg_pkg::OP_SAMPLE:
        s_axis_tready = rd_free && (settle == 2'd0) &&
                        (used <= CW'(tpsg_pkg::OUT_DEPTH - 2));
      tpsg_pkg::OP_TABLE_WRITE: s_axis_tready = (rd_cnt == 2'd0);
      default: s_axis_tready = 1'b1;
    endcase
  end

  assign s_acc   = s_axis_tvalid && s_axis_tready;
  assign smp_acc = s_acc && (s_op == tpsg_pkg::OP_SAMPLE);
  assign prf_acc = s_acc && (s_op == tpsg_pkg::OP_PROFILE);
  assign tw_acc  = s_acc && (s_op == tpsg_pkg::OP_TABLE_WRITE);
  assign idx_ok  = 32'(s_idx) < 32'(TABLE_DEPTH);

  assign cnt_inc = tick_count + 10'd1;
  assign limit   = (prof == tpsg_pkg::PS_PAUSE || prof == tpsg_pkg::PS_REV_PAUSE) ?
                   pause_ticks : step_ticks;
  assign adv     = cnt_inc >= limit;

  always_comb begin
    prof_next = prof;
    tick_next = tick_count;
    if (prf_acc) begin
      tick_next = adv ? 10'd0 : cnt_inc;
      case (prof)
        tpsg_pkg::PS_START:     if (adv) prof_next = tpsg_pkg::PS_LOW;
        tpsg_pkg::PS_LOW:       if (adv) prof_next = tpsg_pkg::PS_MID;
        tpsg_pkg::PS_MID:       if (adv) prof_next = tpsg_pkg::PS_HIGH;
        tpsg_pkg::PS_HIGH:      if (adv) prof_next = tpsg_pkg::PS_PAUSE;
        tpsg_pkg::PS_PAUSE:     if (adv) prof_next = tpsg_pkg::PS_REV_LOW;
        tpsg_pkg::PS_REV_LOW:   if (adv) prof_next = tpsg_pkg::PS_REV_MID;
        tpsg_pkg::PS_REV_MID:   if (adv) prof_next = tpsg_pkg::PS_REV_HIGH;
        tpsg_pkg::PS_REV_HIGH:  if (adv) prof_next = tpsg_pkg::PS_REV_PAUSE;
        tpsg_pkg::PS_REV_PAUSE: if (adv) prof_next = tpsg_pkg::PS_START;
        default: begin
          prof_next = tpsg_pkg::PS_START;
          tick_next = 10'd0;
        end
      endcase
    end
  end

  always_comb begin
    freq_next = frequency;
    en_next   = drive_enable;
    ord_next  = normal_order;
    if (prf_acc && adv) begin
      case (prof)
        tpsg_pkg::PS_START, tpsg_pkg::PS_PAUSE: freq_next = freq_low;
        default: ;
      endcase
      case (prof)
        tpsg_pkg::PS_LOW, tpsg_pkg::PS_REV_LOW: freq_next = freq_mid;
        tpsg_pkg::PS_MID, tpsg_pkg::PS_REV_MID: freq_next = freq_high;
        tpsg_pkg::PS_HIGH, tpsg_pkg::PS_REV_HIGH: en_next = 1'b0;
        tpsg_pkg::PS_PAUSE: begin
          ord_next  = !normal_order;
          en_next   = 1'b1;
        end
        tpsg_pkg::PS_REV_PAUSE: begin
          ord_next = !normal_order;
          en_next  = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prof         <= tpsg_pkg::PS_START;
      tick_count   <= 10'd0;
      frequency    <= tpsg_pkg::FREQUENCY_RESET;
      drive_enable <= 1'b1;
      normal_order <= 1'b1;
    end else begin
      prof         <= prof_next;
      tick_count   <= tick_next;
      frequency    <= freq_next;
      drive_enable <= en_next;
      normal_order <= ord_next;
    end
  end

  // increment pipeline: multiply, then fold whole table steps below the depth
  always_ff @(posedge clk) begin
    prod     <= 24'(phase_gain) * 24'(frequency);
    inc_frac <= prod[15:0];
    inc_idx  <= AW'(tpsg_pkg::reduce_steps(prod[23:16], TABLE_DEPTH));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      settle <= 2'd2;
    end else if (cfg_valid || prf_acc) begin
      settle <= 2'd2;
    end else if (settle != 2'd0) begin
      settle <= settle - 2'd1;
    end
  end

  assign acc_sum = add_wrap(acc_idx, acc_frac, inc_idx, inc_frac);
  assign ph1_sum = add_wrap(acc_idx, acc_frac, OFF1_IDX, OFF1_FRAC);
  assign ph2_sum = add_wrap(acc_idx, acc_frac, OFF2_IDX, OFF2_FRAC);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_idx  <= '0;
      acc_frac <= '0;
    end else if (smp_acc) begin
      acc_idx  <= acc_sum[AW+15:16];
      acc_frac <= acc_sum[15:0];
    end
  end

  always_ff @(posedge clk) begin
    ph1 <= ph1_sum[AW+15:16];
    ph2 <= ph2_sum[AW+15:16];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_cnt <= 2'd0;
      rv_cnt <= 2'd0;
    end else begin
      rv_cnt <= rd_cnt;
      if (smp_acc) begin
        rd_cnt <= 2'd1;
      end else if (rd_cnt == 2'd3) begin
        rd_cnt <= 2'd0;
      end else if (rd_cnt != 2'd0) begin
        rd_cnt <= rd_cnt + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (smp_acc) begin
      j_en  <= drive_enable;
      j_ord <= normal_order;
    end
    if (rd_cnt == 2'd3) begin
      f_en  <= j_en;
      f_ord <= j_ord;
    end
  end

  assign re = (rd_cnt != 2'd0);

  always_comb begin
    case (rd_cnt)
      2'd1:    raddr = acc_idx;
      2'd2:    raddr = ph1;
      default: raddr = ph2;
    endcase
  end

  tpsg_ram #(
    .WIDTH (tpsg_pkg::SAMPLE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (tw_acc && idx_ok),
    .waddr (AW'(s_idx)),
    .wdata (s_val),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rv_cnt == 2'd1) begin
      cls_a <= tpsg_pkg::classify(rdata, upper_threshold, lower_threshold);
    end
    if (rv_cnt == 2'd2) begin
      cls_b <= tpsg_pkg::classify(rdata, upper_threshold, lower_threshold);
    end
  end

  assign fin_en = (rv_cnt == 2'd3);

  always_comb begin
    cls_ph[0] = f_ord ? cls_a : cls_b;
    cls_ph[1] = f_ord ? cls_b : cls_a;
    cls_ph[2] = tpsg_pkg::classify(rdata, upper_threshold, lower_threshold);
    on_mask   = tpsg_pkg::GATE_ALL_OFF;
    off_mask  = '0;
    for (int k = 0; k < 3; k++) begin
      case (cls_ph[k])
        tpsg_pkg::CL_HIGH: begin
          on_mask[2*k]    = 1'b0;
          off_mask[2*k+1] = 1'b1;
        end
        tpsg_pkg::CL_LOW: begin
          on_mask[2*k+1] = 1'b0;
          off_mask[2*k]  = 1'b1;
        end
        default: begin
          off_mask[2*k]   = 1'b1;
          off_mask[2*k+1] = 1'b1;
        end
      endcase
    end
    brk = gate_reg | off_mask;
    fin = brk & on_mask;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gate_reg <= tpsg_pkg::GATE_ALL_OFF;
    end else if (fin_en) begin
      gate_reg <= f_en ? fin : tpsg_pkg::GATE_ALL_OFF;
    end
  end

  assign pop    = m_axis_tvalid && m_axis_tready;
  assign push_n = fin_en ? (f_en ? CW'(2) : CW'(1)) : CW'(0);

  always_ff @(posedge clk) begin
    if (fin_en) begin
      if (f_en) begin
        ent[wptr]                               <= '{last: 1'b0, gate: brk};
        ent[wptr + tpsg_pkg::OUT_PTR_W'(1)]     <= '{last: 1'b1, gate: fin};
      end else begin
        ent[wptr] <= '{last: 1'b1, gate: tpsg_pkg::GATE_ALL_OFF};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
      used <= '0;
    end else begin
      wptr <= wptr + push_n[tpsg_pkg::OUT_PTR_W-1:0];
      rptr <= rptr + {{(tpsg_pkg::OUT_PTR_W-1){1'b0}}, pop};
      cnt  <= cnt + push_n - CW'(pop);
      used <= used + (smp_acc ? CW'(2) : CW'(0)) - CW'(fin_en && !f_en) - CW'(pop);
    end
  end

  assign head          = ent[rptr];
  assign m_axis_tvalid = (cnt != '0);
  assign m_axis_tdata  = {{(tpsg_pkg::M_TDATA_W - GW){1'b0}}, head.gate};
  assign m_axis_tlast  = head.last;

endmodule

>>> rtl/tpsg_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module tpsg_ram #(
  parameter int WIDTH = tpsg_pkg::SAMPLE_W,
  parameter int DEPTH = tpsg_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/tpsg_checker.sv
// Port-level checker of the three-phase sine gate sequencer and its bind.
`timescale 1ns / 1ps

module tpsg_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic [tpsg_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  input logic [tpsg_pkg::OP_W-1:0]        s_axis_tuser,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [tpsg_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  input logic                             m_axis_tlast,
  input logic                             cfg_valid,
  input logic                             cfg_ready,
  input logic [tpsg_pkg::CFG_INDEX_W-1:0] cfg_index,
  input logic [tpsg_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic                        m_acc, smp_acc;
  logic                        prev_last;
  logic [tpsg_pkg::GATE_W-1:0] prev_gate;

  assign m_acc   = m_axis_tvalid && m_axis_tready;
  assign smp_acc = s_axis_tvalid && s_axis_tready && (s_axis_tuser == tpsg_pkg::OP_SAMPLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_last <= 1'b1;
    end else if (m_acc) begin
      prev_last <= m_axis_tlast;
      prev_gate <= m_axis_tdata[tpsg_pkg::GATE_W-1:0];
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output beat changed while stalled");

  a_no_shoot_through: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      (m_axis_tdata[1:0] != 2'b00) && (m_axis_tdata[3:2] != 2'b00) &&
      (m_axis_tdata[5:4] != 2'b00))
    else $error("both switches of one phase driven on");

  a_final_after_break: assert property (@(posedge clk) disable iff (rst)
    m_acc && !prev_last |->
      m_axis_tlast && ((m_axis_tdata[tpsg_pkg::GATE_W-1:0] & ~prev_gate) == '0))
    else $error("final beat releases a switch the break beat kept on");

  a_sample_spacing: assert property (@(posedge clk) disable iff (rst)
    smp_acc |=> !smp_acc ##1 !smp_acc)
    else $error("sample ticks taken closer than three cycles apart");

endmodule

bind three_phase_sine_gate_sequencer tpsg_checker u_tpsg_checker (.*);
